[design/cia_pkg.sv]
// ----------------------------------------------------------------------------
// Circle overlap area: shared package
// Widths, case codes, pipeline structs and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package cia_pkg;

	// field widths
	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int DIFF_W  = 25;
	localparam int MAG_W   = 24;
	localparam int SQ_W    = 48;
	localparam int SQ_H    = 24;
	localparam int R2_W    = 46;
	localparam int R2_H    = 23;
	localparam int D2_W    = 49;
	localparam int N_W     = 51;
	localparam int P_W     = 96;
	localparam int ROOT_W  = 48;
	localparam int REM_W   = 51;
	localparam int NORM_W  = 52;
	localparam int CX_W    = 56;
	localparam int Z_W     = 34;
	localparam int ANG_W   = 32;
	localparam int PROD_W  = 80;
	localparam int U_SHIFT = 29;
	localparam int U_W     = 51;
	localparam int AREA_W  = 32;
	localparam int KIND_W  = 2;

	// step counts
	localparam int SQRT_STEPS   = 48;
	localparam int NORM_STEPS   = 6;
	localparam int CORDIC_STEPS = 31;

	// case codes
	localparam logic [KIND_W-1:0] KIND_DISJOINT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CONTAINED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PARTIAL   = 2'd2;

	// angles, unsigned Q2.30 radians
	localparam logic [ANG_W-1:0] PI_Q30      = 32'd3373259426;
	localparam logic [ANG_W-1:0] HALF_PI_Q30 = 32'd1686629713;

	// data that rides alongside the arithmetic
	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic [R2_W-1:0]          ra2;
		logic [R2_W-1:0]          rb2;
		logic signed [N_W-1:0]    n1;
		logic signed [N_W-1:0]    n2;
		logic [AREA_W-1:0]        carea;
		logic [ROOT_W-1:0]        root;
	} side_t;

	// vector during normalisation
	typedef struct packed {
		logic [NORM_W-1:0] x;
		logic [NORM_W-1:0] y;
		logic [ANG_W-1:0]  z;
		logic              zero;
	} nvec_t;

	// vector during CORDIC rotation
	typedef struct packed {
		logic signed [CX_W-1:0] x;
		logic signed [CX_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   zero;
	} cvec_t;

	// atan(2^-i) in Q2.30
	function automatic logic [ANG_W-1:0] atan_q30(input int unsigned idx);
		logic [ANG_W-1:0] r;
		case (idx)
			0:  r = 32'h3243F6A8;
			1:  r = 32'h1DAC6705;
			2:  r = 32'h0FADBAFC;
			3:  r = 32'h07F56EA6;
			4:  r = 32'h03FEAB76;
			5:  r = 32'h01FFD55B;
			6:  r = 32'h00FFFAAA;
			7:  r = 32'h007FFF55;
			8:  r = 32'h003FFFEA;
			9:  r = 32'h001FFFFD;
			10: r = 32'h000FFFFF;
			11: r = 32'h0007FFFF;
			12: r = 32'h0003FFFF;
			13: r = 32'h0001FFFF;
			14: r = 32'h0000FFFF;
			15: r = 32'h00007FFF;
			16: r = 32'h00003FFF;
			17: r = 32'h00001FFF;
			18: r = 32'h00000FFF;
			19: r = 32'h000007FF;
			20: r = 32'h000003FF;
			21: r = 32'h000001FF;
			22: r = 32'h000000FF;
			23: r = 32'h0000007F;
			24: r = 32'h0000003F;
			25: r = 32'h0000001F;
			26: r = 32'h0000000F;
			27: r = 32'h00000008;
			28: r = 32'h00000004;
			29: r = 32'h00000002;
			30: r = 32'h00000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[design/cia_if.sv]
// ----------------------------------------------------------------------------
// Circle overlap area: channel interfaces
// Valid/ready channels for circle pairs in and overlap results out.
// ----------------------------------------------------------------------------
interface cia_circ_if;
	import cia_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] center_a_x;
	logic signed [COORD_W-1:0] center_a_y;
	logic [RAD_W-1:0]          radius_a;
	logic signed [COORD_W-1:0] center_b_x;
	logic signed [COORD_W-1:0] center_b_y;
	logic [RAD_W-1:0]          radius_b;

	modport source (
		output valid, center_a_x, center_a_y, radius_a,
		output center_b_x, center_b_y, radius_b,
		input  ready
	);
	modport sink (
		input  valid, center_a_x, center_a_y, radius_a,
		input  center_b_x, center_b_y, radius_b,
		output ready
	);
endinterface

interface cia_area_if;
	import cia_pkg::*;

	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] overlap_area;
	logic [KIND_W-1:0] overlap_case;

	modport source (output valid, overlap_area, overlap_case, input ready);
	modport sink   (input valid, overlap_area, overlap_case, output ready);
endinterface

[design/cia_front.sv]
// ----------------------------------------------------------------------------
// Circle overlap area: front end
// Squares, case decision, radicand product and contained-case area.
// ----------------------------------------------------------------------------
module cia_front #(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	cia_circ_if.sink                circles,
	output logic                    valid,
	output cia_pkg::side_t          side,
	output logic [cia_pkg::P_W-1:0] p
);
	import cia_pkg::*;

	localparam int CSHIFT = FRAC_BITS + 30;
	localparam int CRND   = FRAC_BITS + 29;

	logic ld1;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	// stage 1: centre differences
	logic signed [DIFF_W-1:0] dx_s1, dy_s1;
	logic [RAD_W-1:0]         ra_s1, rb_s1;

	// stage 2: squares
	logic [MAG_W-1:0]  ux, uy, rsum;
	logic [RAD_W-1:0]  rdif;
	logic [SQ_W-1:0]   ux2_s2, uy2_s2, sum2_s2;
	logic [R2_W-1:0]   dif2_s2, ra2_s2, rb2_s2;

	// stage 3: squared distance
	logic [D2_W-1:0]   d2_s3;
	logic [SQ_W-1:0]   sum2_s3;
	logic [R2_W-1:0]   dif2_s3, ra2_s3, rb2_s3;

	// stage 4: classification
	logic [KIND_W-1:0]     kind;
	logic [KIND_W-1:0]     kind_s4;
	logic [SQ_W-1:0]       a_s4, b_s4;
	logic signed [N_W-1:0] n1_s4, n2_s4;
	logic [R2_W-1:0]       ra2_s4, rb2_s4, rmin2_s4;

	// stage 5: partial products
	logic [KIND_W-1:0]          kind_s5;
	logic [SQ_W-1:0]            phh_s5, phl_s5, plh_s5, pll_s5;
	logic [R2_H+ANG_W-1:0]      chi_s5, clo_s5;
	logic signed [N_W-1:0]      n1_s5, n2_s5;
	logic [R2_W-1:0]            ra2_s5, rb2_s5;

	// stage 6: sums
	logic [PROD_W-1:0] cprod, csh;
	side_t             side_s6;
	logic [P_W-1:0]    p_s6;

	assign ld1           = en || !v_s1;
	assign circles.ready = ld1;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= circles.valid;
			end
			if (en) begin
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
			end
		end
	end

	// stage 1
	always_ff @(posedge clk) begin
		if (ld1) begin
			dx_s1 <= DIFF_W'(circles.center_b_x) - DIFF_W'(circles.center_a_x);
			dy_s1 <= DIFF_W'(circles.center_b_y) - DIFF_W'(circles.center_a_y);
			ra_s1 <= circles.radius_a;
			rb_s1 <= circles.radius_b;
		end
	end

	// stage 2 inputs: magnitudes and radius sum/difference
	always_comb begin
		ux   = dx_s1[DIFF_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
		uy   = dy_s1[DIFF_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
		rsum = MAG_W'(ra_s1) + MAG_W'(rb_s1);
		rdif = (ra_s1 > rb_s1) ? ra_s1 - rb_s1 : rb_s1 - ra_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux2_s2  <= SQ_W'(ux) * SQ_W'(ux);
			uy2_s2  <= SQ_W'(uy) * SQ_W'(uy);
			sum2_s2 <= SQ_W'(rsum) * SQ_W'(rsum);
			dif2_s2 <= R2_W'(rdif) * R2_W'(rdif);
			ra2_s2  <= R2_W'(ra_s1) * R2_W'(ra_s1);
			rb2_s2  <= R2_W'(rb_s1) * R2_W'(rb_s1);
		end
	end

	// stage 3
	always_ff @(posedge clk) begin
		if (en) begin
			d2_s3   <= D2_W'(ux2_s2) + D2_W'(uy2_s2);
			sum2_s3 <= sum2_s2;
			dif2_s3 <= dif2_s2;
			ra2_s3  <= ra2_s2;
			rb2_s3  <= rb2_s2;
		end
	end

	// stage 4: touching counts as disjoint on the outside, contained on the inside
	always_comb begin
		if (d2_s3 >= D2_W'(sum2_s3)) begin
			kind = KIND_DISJOINT;
		end else if (d2_s3 <= D2_W'(dif2_s3)) begin
			kind = KIND_CONTAINED;
		end else begin
			kind = KIND_PARTIAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s4  <= kind;
			a_s4     <= SQ_W'(D2_W'(sum2_s3) - d2_s3);
			b_s4     <= SQ_W'(d2_s3 - D2_W'(dif2_s3));
			n1_s4    <= $signed(N_W'(d2_s3)) + $signed(N_W'(ra2_s3)) - $signed(N_W'(rb2_s3));
			n2_s4    <= $signed(N_W'(d2_s3)) + $signed(N_W'(rb2_s3)) - $signed(N_W'(ra2_s3));
			ra2_s4   <= ra2_s3;
			rb2_s4   <= rb2_s3;
			rmin2_s4 <= (ra2_s3 < rb2_s3) ? ra2_s3 : rb2_s3;
		end
	end

	// stage 5: 24x24 partials of the radicand, 23x32 partials of rmin^2*pi
	always_ff @(posedge clk) begin
		if (en) begin
			kind_s5 <= kind_s4;
			phh_s5  <= SQ_W'(a_s4[SQ_W-1:SQ_H]) * SQ_W'(b_s4[SQ_W-1:SQ_H]);
			phl_s5  <= SQ_W'(a_s4[SQ_W-1:SQ_H]) * SQ_W'(b_s4[SQ_H-1:0]);
			plh_s5  <= SQ_W'(a_s4[SQ_H-1:0]) * SQ_W'(b_s4[SQ_W-1:SQ_H]);
			pll_s5  <= SQ_W'(a_s4[SQ_H-1:0]) * SQ_W'(b_s4[SQ_H-1:0]);
			chi_s5  <= (R2_H+ANG_W)'(rmin2_s4[R2_W-1:R2_H]) * (R2_H+ANG_W)'(PI_Q30);
			clo_s5  <= (R2_H+ANG_W)'(rmin2_s4[R2_H-1:0]) * (R2_H+ANG_W)'(PI_Q30);
			n1_s5   <= n1_s4;
			n2_s5   <= n2_s4;
			ra2_s5  <= ra2_s4;
			rb2_s5  <= rb2_s4;
		end
	end

	// stage 6: contained area rounds half up and saturates
	always_comb begin
		cprod = (PROD_W'(chi_s5) << R2_H) + PROD_W'(clo_s5) + (PROD_W'(1) << CRND);
		csh   = cprod >> CSHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s6 <= (P_W'(phh_s5) << SQ_W) + (P_W'(phl_s5) << SQ_H)
				+ (P_W'(plh_s5) << SQ_H) + P_W'(pll_s5);
			side_s6.kind  <= kind_s5;
			side_s6.ra2   <= ra2_s5;
			side_s6.rb2   <= rb2_s5;
			side_s6.n1    <= n1_s5;
			side_s6.n2    <= n2_s5;
			side_s6.carea <= (|csh[PROD_W-1:AREA_W]) ? '1 : csh[AREA_W-1:0];
			side_s6.root  <= '0;
		end
	end

	assign valid = v_s6;
	assign side  = side_s6;
	assign p     = p_s6;

endmodule

[design/cia_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// Circle overlap area: square root cell
// One restoring step of the integer square root: two radicand bits in,
// one root bit out.
// ----------------------------------------------------------------------------
module cia_sqrt_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  cia_pkg::side_t             in_side,
	input  logic [cia_pkg::P_W-1:0]    in_p,
	input  logic [cia_pkg::REM_W-1:0]  in_rem,
	input  logic [cia_pkg::ROOT_W-1:0] in_root,
	output logic                       valid_q,
	output cia_pkg::side_t             side_q,
	output logic [cia_pkg::P_W-1:0]    p_q,
	output logic [cia_pkg::REM_W-1:0]  rem_q,
	output logic [cia_pkg::ROOT_W-1:0] root_q
);
	import cia_pkg::*;

	logic [REM_W-1:0] rem_sh, trial;
	logic             ge;

	// trial subtract of (root << 2) | 1
	always_comb begin
		rem_sh = {in_rem[REM_W-3:0], in_p[P_W-1 -: 2]};
		trial  = REM_W'({in_root, 2'b01});
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			p_q    <= in_p << 2;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {in_root[ROOT_W-2:0], ge};
		end
	end

endmodule

[design/cia_norm_cell.sv]
// ----------------------------------------------------------------------------
// Circle overlap area: normalisation cell
// Shifts each vector left by a fixed amount when the top bits of its
// larger component are clear; a row of these finds the leading one.
// ----------------------------------------------------------------------------
module cia_norm_cell #(
	parameter int SHIFT = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  cia_pkg::side_t in_side,
	input  cia_pkg::nvec_t in_a,
	input  cia_pkg::nvec_t in_b,
	output logic           valid_q,
	output cia_pkg::side_t side_q,
	output cia_pkg::nvec_t a_q,
	output cia_pkg::nvec_t b_q
);
	import cia_pkg::*;

	logic [NORM_W-1:0] or_a, or_b;
	nvec_t             na, nb;

	// top bits of max(x, y) are clear exactly when those of x | y are
	always_comb begin
		or_a = in_a.x | in_a.y;
		or_b = in_b.x | in_b.y;
		na   = in_a;
		nb   = in_b;
		if (or_a[NORM_W-1 -: SHIFT] == '0) begin
			na.x = in_a.x << SHIFT;
			na.y = in_a.y << SHIFT;
		end
		if (or_b[NORM_W-1 -: SHIFT] == '0) begin
			nb.x = in_b.x << SHIFT;
			nb.y = in_b.y << SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			a_q    <= na;
			b_q    <= nb;
		end
	end

endmodule

[design/cia_cordic_cell.sv]
// ----------------------------------------------------------------------------
// Circle overlap area: CORDIC cell
// One vectoring micro-rotation for each of the two angle vectors.
// ----------------------------------------------------------------------------
module cia_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  cia_pkg::side_t in_side,
	input  cia_pkg::cvec_t in_a,
	input  cia_pkg::cvec_t in_b,
	output logic           valid_q,
	output cia_pkg::side_t side_q,
	output cia_pkg::cvec_t a_q,
	output cia_pkg::cvec_t b_q
);
	import cia_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(atan_q30(STEP));

	// drive y towards zero, accumulate the angle turned
	function automatic cvec_t rotate(input cvec_t v);
		cvec_t                  r;
		logic signed [CX_W-1:0] sx, sy;
		sx = $signed(v.y) >>> STEP;
		sy = $signed(v.x) >>> STEP;
		r  = v;
		if (!v.y[CX_W-1]) begin
			r.x = v.x + sx;
			r.y = v.y - sy;
			r.z = v.z + ATAN_Z;
		end else begin
			r.x = v.x - sx;
			r.y = v.y + sy;
			r.z = v.z - ATAN_Z;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			a_q    <= rotate(in_a);
			b_q    <= rotate(in_b);
		end
	end

endmodule

[design/cia_back.sv]
// ----------------------------------------------------------------------------
// Circle overlap area: back end
// Clamps the angles, weights them by the squared radii, removes the
// triangle term and picks the area for the case.
// ----------------------------------------------------------------------------
module cia_back #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  cia_pkg::side_t             in_side,
	input  cia_pkg::cvec_t             in_a,
	input  cia_pkg::cvec_t             in_b,
	output logic                       valid,
	output logic [cia_pkg::AREA_W-1:0] area,
	output logic [cia_pkg::KIND_W-1:0] kind
);
	import cia_pkg::*;

	localparam int V_W = U_W + 1;
	localparam int PP_W = R2_H + ANG_W;

	logic [ANG_W-1:0] alpha, beta;

	logic              v_s1, v_s2;
	logic [PP_W-1:0]   pah_s1, pal_s1, pbh_s1, pbl_s1;
	logic [KIND_W-1:0] kind_s1, kind_s2;
	logic [ROOT_W-1:0] root_s1, root_s2;
	logic [AREA_W-1:0] carea_s1, carea_s2;
	logic [PROD_W-1:0] acc;
	logic [U_W-1:0]    u_s2;

	logic [U_W-1:0]    vdiff;
	logic [V_W-1:0]    rnd;

	// angle result limited to [0, pi]
	function automatic logic [ANG_W-1:0] clamp(input cvec_t v);
		logic [ANG_W-1:0] r;
		if (v.zero || v.z[Z_W-1]) begin
			r = '0;
		end else if (v.z > $signed(Z_W'(PI_Q30))) begin
			r = PI_Q30;
		end else begin
			r = ANG_W'(v.z);
		end
		return r;
	endfunction

	always_comb begin
		alpha = clamp(in_a);
		beta  = clamp(in_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// stage 1: split products of r^2 and angle
	always_ff @(posedge clk) begin
		if (en) begin
			pah_s1   <= PP_W'(in_side.ra2[R2_W-1:R2_H]) * PP_W'(alpha);
			pal_s1   <= PP_W'(in_side.ra2[R2_H-1:0]) * PP_W'(alpha);
			pbh_s1   <= PP_W'(in_side.rb2[R2_W-1:R2_H]) * PP_W'(beta);
			pbl_s1   <= PP_W'(in_side.rb2[R2_H-1:0]) * PP_W'(beta);
			kind_s1  <= in_side.kind;
			root_s1  <= in_side.root;
			carea_s1 <= in_side.carea;
		end
	end

	// stage 2: sum of the two sector terms
	assign acc = (PROD_W'(pah_s1) << R2_H) + PROD_W'(pal_s1)
		+ (PROD_W'(pbh_s1) << R2_H) + PROD_W'(pbl_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2     <= U_W'(acc >> U_SHIFT);
			kind_s2  <= kind_s1;
			root_s2  <= root_s1;
			carea_s2 <= carea_s1;
		end
	end

	// triangle term, floor at zero, round half up, saturate
	always_comb begin
		vdiff = (u_s2 > U_W'(root_s2)) ? u_s2 - U_W'(root_s2) : '0;
		rnd   = (V_W'(vdiff) + (V_W'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
		case (kind_s2)
			KIND_DISJOINT:  area = '0;
			KIND_CONTAINED: area = carea_s2;
			KIND_PARTIAL:   area = (|rnd[V_W-1:AREA_W]) ? '1 : rnd[AREA_W-1:0];
			default:        area = '0;
		endcase
	end

	assign valid = v_s2;
	assign kind  = kind_s2;

endmodule

[design/circle_intersection_area_top.sv]
// Throughput: one transaction per cycle when no result is stalled; the
//   48-cell square root row and the 31-cell CORDIC row are fully pipelined,
//   so it rests on the single output register and the advance it controls.
// Reset: arst_n clears all valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Circle overlap area: top level
// Area of intersection of two circles, with a case code, as a pipeline of
// square root, normalisation and CORDIC cells.
// ----------------------------------------------------------------------------
module circle_intersection_area_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cia_circ_if.sink   circles,
	cia_area_if.source overlap
);
	import cia_pkg::*;

	logic en;

	// front end
	logic           f_valid;
	side_t          f_side;
	logic [P_W-1:0] f_p;

	// square root row
	logic              sq_valid [0:SQRT_STEPS];
	side_t             sq_side  [0:SQRT_STEPS];
	logic [P_W-1:0]    sq_p     [0:SQRT_STEPS];
	logic [REM_W-1:0]  sq_rem   [0:SQRT_STEPS];
	logic [ROOT_W-1:0] sq_root  [0:SQRT_STEPS];

	// pre-rotation stage
	nvec_t pa, pb;
	side_t pside;
	logic  pr_valid_q;
	side_t pr_side_q;
	nvec_t pr_a_q, pr_b_q;

	// normalisation row
	logic  nm_valid [0:NORM_STEPS];
	side_t nm_side  [0:NORM_STEPS];
	nvec_t nm_a     [0:NORM_STEPS];
	nvec_t nm_b     [0:NORM_STEPS];

	// CORDIC row
	logic  cd_valid [0:CORDIC_STEPS];
	side_t cd_side  [0:CORDIC_STEPS];
	cvec_t cd_a     [0:CORDIC_STEPS];
	cvec_t cd_b     [0:CORDIC_STEPS];

	// back end and output register
	logic              b_valid;
	logic [AREA_W-1:0] b_area;
	logic [KIND_W-1:0] b_kind;
	logic              out_valid_q;
	logic [AREA_W-1:0] out_area_q;
	logic [KIND_W-1:0] out_kind_q;

	// whole pipeline advances unless a result is held at the output
	assign en = !out_valid_q || overlap.ready;

	cia_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.circles (circles),
		.valid   (f_valid),
		.side    (f_side),
		.p       (f_p)
	);

	assign sq_valid[0] = f_valid;
	assign sq_side[0]  = f_side;
	assign sq_p[0]     = f_p;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		cia_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sq_valid[g]),
			.in_side  (sq_side[g]),
			.in_p     (sq_p[g]),
			.in_rem   (sq_rem[g]),
			.in_root  (sq_root[g]),
			.valid_q  (sq_valid[g+1]),
			.side_q   (sq_side[g+1]),
			.p_q      (sq_p[g+1]),
			.rem_q    (sq_rem[g+1]),
			.root_q   (sq_root[g+1])
		);
	end

	// pre-rotate by pi/2 when the cosine term is negative
	function automatic nvec_t prerot(input logic signed [N_W-1:0] n,
	                                 input logic [ROOT_W-1:0] s);
		nvec_t r;
		if (n[N_W-1]) begin
			r.x = NORM_W'(s);
			r.y = NORM_W'(-n);
			r.z = HALF_PI_Q30;
		end else begin
			r.x = NORM_W'(n);
			r.y = NORM_W'(s);
			r.z = '0;
		end
		r.zero = (r.x == '0) && (r.y == '0);
		return r;
	endfunction

	always_comb begin
		pside      = sq_side[SQRT_STEPS];
		pside.root = sq_root[SQRT_STEPS];
		pa         = prerot(pside.n1, sq_root[SQRT_STEPS]);
		pb         = prerot(pside.n2, sq_root[SQRT_STEPS]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pr_valid_q <= 1'b0;
		end else if (en) begin
			pr_valid_q <= sq_valid[SQRT_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_side_q <= pside;
			pr_a_q    <= pa;
			pr_b_q    <= pb;
		end
	end

	assign nm_valid[0] = pr_valid_q;
	assign nm_side[0]  = pr_side_q;
	assign nm_a[0]     = pr_a_q;
	assign nm_b[0]     = pr_b_q;

	// shifts of 32, 16, 8, 4, 2, 1
	for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
		cia_norm_cell #(.SHIFT(1 << (NORM_STEPS - 1 - g))) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (nm_valid[g]),
			.in_side  (nm_side[g]),
			.in_a     (nm_a[g]),
			.in_b     (nm_b[g]),
			.valid_q  (nm_valid[g+1]),
			.side_q   (nm_side[g+1]),
			.a_q      (nm_a[g+1]),
			.b_q      (nm_b[g+1])
		);
	end

	// widen into signed CORDIC vectors
	always_comb begin
		cd_valid[0]     = nm_valid[NORM_STEPS];
		cd_side[0]      = nm_side[NORM_STEPS];
		cd_a[0].x       = CX_W'(nm_a[NORM_STEPS].x);
		cd_a[0].y       = CX_W'(nm_a[NORM_STEPS].y);
		cd_a[0].z       = Z_W'(nm_a[NORM_STEPS].z);
		cd_a[0].zero    = nm_a[NORM_STEPS].zero;
		cd_b[0].x       = CX_W'(nm_b[NORM_STEPS].x);
		cd_b[0].y       = CX_W'(nm_b[NORM_STEPS].y);
		cd_b[0].z       = Z_W'(nm_b[NORM_STEPS].z);
		cd_b[0].zero    = nm_b[NORM_STEPS].zero;
	end

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		cia_cordic_cell #(.STEP(g)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (cd_valid[g]),
			.in_side  (cd_side[g]),
			.in_a     (cd_a[g]),
			.in_b     (cd_b[g]),
			.valid_q  (cd_valid[g+1]),
			.side_q   (cd_side[g+1]),
			.a_q      (cd_a[g+1]),
			.b_q      (cd_b[g+1])
		);
	end

	cia_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (cd_valid[CORDIC_STEPS]),
		.in_side  (cd_side[CORDIC_STEPS]),
		.in_a     (cd_a[CORDIC_STEPS]),
		.in_b     (cd_b[CORDIC_STEPS]),
		.valid    (b_valid),
		.area     (b_area),
		.kind     (b_kind)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= b_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_area_q <= b_area;
			out_kind_q <= b_kind;
		end
	end

	assign overlap.valid        = out_valid_q;
	assign overlap.overlap_area = out_area_q;
	assign overlap.overlap_case = out_kind_q;

`ifndef SYNTH
	// a disjoint pair never reports area
	a_disjoint_zero: assert property (@(posedge clk) disable iff (!arst_n)
		overlap.valid && overlap.overlap_case == KIND_DISJOINT |-> overlap.overlap_area == '0)
		else $error("disjoint result with nonzero area");

	// input held off only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!circles.ready |-> overlap.valid && !overlap.ready)
		else $error("input stalled without output back-pressure");

	// partial overlap always has a positive triangle term
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pr_valid_q && pr_side_q.kind == KIND_PARTIAL |-> pr_side_q.root != '0)
		else $error("partial overlap with zero root");

	// a stalled pipeline keeps its pre-rotated vectors
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en && pr_valid_q |=> pr_valid_q && $stable(pr_a_q) && $stable(pr_b_q))
		else $error("pipeline moved during a stall");
`endif

endmodule

[tb/circle_intersection_area_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circle overlap area: testbench
// Drives circle pairs into the pipeline with random gaps and output stalls,
// predicts area and case code in fixed point, and checks every transaction.
// ----------------------------------------------------------------------------

// Expected overlap results, oldest first
class overlap_scoreboard;
	typedef struct {
		logic [31:0] area;
		logic [1:0]  kind;
	} overlap_t;

	overlap_t pending[$];
	int errors;

	// atan(2^-i) in Q2.30
	function automatic longint atan_step(int i);
		return longint'(cia_pkg::atan_q30(i));
	endfunction

	// atan2(y, x) for y >= 0, Q2.30 in [0, pi]
	function automatic longint cordic_angle(longint x, longint y);
		longint z, m, t, sx, sy;
		z = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = longint'(cia_pkg::HALF_PI_Q30);
		end
		if (x == 0 && y == 0)
			return z;
		m = (x > y) ? x : y;
		while (m < (64'sd1 <<< 51)) begin
			m = m * 2;
			x = x * 2;
			y = y * 2;
		end
		for (int i = 0; i < 31; i++) begin
			sx = y >>> i;
			sy = x >>> i;
			if (y >= 0) begin
				x += sx; y -= sy; z += atan_step(i);
			end else begin
				x -= sx; y += sy; z -= atan_step(i);
			end
		end
		if (z < 0) z = 0;
		if (z > longint'(cia_pkg::PI_Q30)) z = longint'(cia_pkg::PI_Q30);
		return z;
	endfunction

	// bitwise floor square root of a 96-bit value
	function automatic logic [63:0] isqrt96(logic [127:0] a);
		logic [63:0] rem, root, trial;
		rem = 0;
		root = 0;
		for (int i = 47; i >= 0; i--) begin
			rem = (rem << 2) | a[2*i +: 2];
			trial = (root << 2) | 1;
			root = root << 1;
			if (rem >= trial) begin
				rem -= trial;
				root |= 1;
			end
		end
		return root;
	endfunction

	function void note_circles(logic signed [23:0] ax, logic signed [23:0] ay,
			logic [22:0] ra, logic signed [23:0] bx, logic signed [23:0] by,
			logic [22:0] rb);
		longint dx, dy, n1, n2;
		logic [63:0] d2, sum2, df, dif2, ra2, rb2, rmin, s, u, v, alpha, beta;
		logic [127:0] wide;
		overlap_t e;
		dx = longint'(bx) - longint'(ax);
		dy = longint'(by) - longint'(ay);
		d2 = dx * dx + dy * dy;
		sum2 = (ra + 64'd0 + rb) * (ra + 64'd0 + rb);
		df = (ra > rb) ? ra - rb : rb - ra;
		dif2 = df * df;
		ra2 = ra * 64'd1 * ra;
		rb2 = rb * 64'd1 * rb;
		if (d2 >= sum2) begin
			e.area = 0;
			e.kind = cia_pkg::KIND_DISJOINT;
		end else if (d2 <= dif2) begin
			rmin = (ra < rb) ? ra : rb;
			wide = 128'(rmin * rmin) * 128'(cia_pkg::PI_Q30) + (128'd1 << 45);
			wide = wide >> 46;
			e.area = (wide > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
			e.kind = cia_pkg::KIND_CONTAINED;
		end else begin
			s = isqrt96(128'(sum2 - d2) * 128'(d2 - dif2));
			n1 = longint'(d2) + longint'(ra2) - longint'(rb2);
			n2 = longint'(d2) + longint'(rb2) - longint'(ra2);
			alpha = cordic_angle(n1, longint'(s));
			beta = cordic_angle(n2, longint'(s));
			wide = 128'(ra2) * 128'(alpha) + 128'(rb2) * 128'(beta);
			u = wide[92:29];
			v = (u > s) ? u - s : 0;
			v = (v + (64'd1 << 16)) >> 17;
			e.area = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
			e.kind = cia_pkg::KIND_PARTIAL;
		end
		pending = {pending, e};
	endfunction

	task report(string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	task check_overlap(logic [31:0] area, logic [1:0] kind);
		overlap_t e;
		if (pending.size() == 0) begin
			report($sformatf("unexpected result area=%0d case=%0d", area, kind));
			return;
		end
		e = pending.pop_front();
		if (area !== e.area)
			report($sformatf("area got %0d want %0d", area, e.area));
		if (kind !== e.kind)
			report($sformatf("case got %0d want %0d", kind, e.kind));
	endtask
endclass

module circle_intersection_area_top_test;
	import cia_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   send_idle_pct = 38;
	int   recv_idle_pct = 38;
	bit   recv_hold = 0;
	bit   stim_done = 0;
	overlap_scoreboard sb = new();

	cia_circ_if circles();
	cia_area_if overlap();

	circle_intersection_area_top #(.FRAC_BITS(16)) uut (
		.clk(clk), .arst_n(arst_n), .circles(circles.sink), .overlap(overlap.source)
	);

	always #10 clk = ~clk;

	initial begin
		circles.valid = 0;
		circles.center_a_x = 0;
		circles.center_a_y = 0;
		circles.radius_a = 0;
		circles.center_b_x = 0;
		circles.center_b_y = 0;
		circles.radius_b = 0;
		overlap.ready = 0;
	end

	// note accepted circle pairs, check accepted results
	always @(posedge clk) begin
		if (arst_n && circles.valid && circles.ready)
			sb.note_circles(circles.center_a_x, circles.center_a_y, circles.radius_a,
				circles.center_b_x, circles.center_b_y, circles.radius_b);
		if (arst_n && overlap.valid && overlap.ready)
			sb.check_overlap(overlap.overlap_area, overlap.overlap_case);
	end

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (!arst_n || recv_hold)
			overlap.ready <= 0;
		else
			overlap.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// offer one pair, hold until accepted, then idle a random number of cycles
	task send_pair(logic signed [23:0] ax, logic signed [23:0] ay, logic [22:0] ra,
			logic signed [23:0] bx, logic signed [23:0] by, logic [22:0] rb);
		circles.valid <= 1;
		circles.center_a_x <= ax;
		circles.center_a_y <= ay;
		circles.radius_a <= ra;
		circles.center_b_x <= bx;
		circles.center_b_y <= by;
		circles.radius_b <= rb;
		do @(posedge clk); while (!circles.ready);
		while ($urandom_range(99) < send_idle_pct) begin
			circles.valid <= 0;
			@(posedge clk);
		end
	endtask

	task send_random();
		logic signed [23:0] ax, ay, bx, by;
		logic [22:0] ra, rb;
		int mode;
		mode = $urandom_range(9);
		ax = 24'($urandom); ay = 24'($urandom); ra = 23'($urandom);
		if (mode < 6) begin
			// nearby circles of similar scale, mostly overlapping
			ra = 23'($urandom_range(1, (mode < 3) ? 23'h3FFFF : 23'h7FFFFF));
			rb = 23'($urandom_range(1, ra * 2 > 23'h7FFFFF ? 23'h7FFFFF : ra * 2));
			bx = ax + $signed(24'($urandom_range(0, 2 * ra)) - 24'(ra));
			by = ay + $signed(24'($urandom_range(0, 2 * ra)) - 24'(ra));
		end else begin
			bx = 24'($urandom); by = 24'($urandom); rb = 23'($urandom);
		end
		send_pair(ax, ay, ra, bx, by, rb);
	endtask

	task wait_drained();
		circles.valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	initial begin
		int hold;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, touching, concentric, zero radii, saturation
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 23'h10000, 24'h20000, 0, 23'h10000);
		send_pair(0, 0, 23'h20000, 24'h10000, 0, 23'h10000);
		send_pair(0, 0, 23'h10000, 24'h10000, 0, 23'h10000);
		send_pair(0, 0, 23'h7FFFFF, 0, 0, 23'h7FFFFF);
		send_pair(24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF, 24'h800000, 24'h800000,
			23'h7FFFFF);
		send_pair(24'h800000, 24'h800000, 23'h7FFFFF, 24'h800000, 24'h800000, 0);
		send_pair(0, 0, 23'h7FFFFF, 24'h7FFFFF, 0, 23'h7FFFFF);
		send_pair(0, 0, 23'h40000, 24'hFC0000, 0, 23'h10000);
		send_pair(0, 0, 1, 0, 0, 1);
		send_pair(0, 0, 1, 1, 0, 1);
		send_pair(24'h123456, 24'hFEDCBA, 23'h30000, 24'h140000, 24'hFF0000, 23'h28000);
		send_pair(0, 0, 23'h5555, 24'h2AAA, 24'h2AAA, 23'h2AAAAA);
		send_pair(24'h7FFFFF, 0, 23'h7FFFFF, 24'h800000, 0, 23'h7FFFFF);
		send_pair(0, 24'h7FFFFF, 23'h7FFFFF, 0, 24'h800000, 0);
		send_pair(24'h10000, 24'h10000, 23'h10000, 24'h10000, 24'h10000, 0);

		// random, a stretch with no idling, then one with random gaps and stalls
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (80) send_random();
		send_idle_pct = 38;
		recv_idle_pct = 38;
		repeat (150) send_random();

		// receiver holds off while the sender keeps offering
		fork
			begin
				recv_hold = 1;
				for (hold = 0; hold < 300; hold++) @(posedge clk);
				recv_hold = 0;
			end
			repeat (150) send_random();
		join

		// sender pauses until all results are back
		wait_drained();
		repeat (130) send_random();

		wait_drained();
		stim_done = 1;
	end

	initial begin
		wait (stim_done);
		repeat (120) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS circle_intersection_area_top");
		else
			$display("FAIL circle_intersection_area_top");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL circle_intersection_area_top");
		$finish;
	end

endmodule

[sim.f]
design/cia_pkg.sv
design/cia_if.sv
design/cia_front.sv
design/cia_sqrt_cell.sv
design/cia_norm_cell.sv
design/cia_cordic_cell.sv
design/cia_back.sv
design/circle_intersection_area_top.sv
tb/circle_intersection_area_top_test.sv
